// File: rtl/core/cvtc_pkg.sv
// cvtc_pkg: shared types, character codes and phase-step functions for the
// config value type classifier
// depends on nothing; imported by every module of the block
package cvtc_pkg;

  // result codes, in the order they are tested
  typedef enum logic [2:0] {
    VT_STRING  = 3'd0,
    VT_INTEGER = 3'd1,
    VT_DECIMAL = 3'd2,
    VT_BOOLEAN = 3'd3,
    VT_ARRAY   = 3'd4,
    VT_INVALID = 3'd5
  } value_type_e;

  // integer recognizer phases
  typedef enum logic [1:0] {
    INT_START  = 2'd0,
    INT_SIGN   = 2'd1,
    INT_DIGITS = 2'd2,
    INT_DEAD   = 2'd3
  } int_phase_e;

  // decimal recognizer phases
  typedef enum logic [2:0] {
    DEC_START = 3'd0,
    DEC_SIGN  = 3'd1,
    DEC_INT   = 3'd2,
    DEC_DOT   = 3'd3,
    DEC_FRAC  = 3'd4,
    DEC_DEAD  = 3'd5
  } dec_phase_e;

  // one input item
  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } item_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [2:0] POS_MAX = 3'd7;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_sign(input logic [7:0] c);
    return (c == CH_MINUS) || (c == CH_PLUS);
  endfunction

  // letters of "true" by position
  function automatic logic [7:0] true_char(input logic [1:0] idx);
    logic [7:0] r;
    unique case (idx)
      2'd0: r = 8'h74;
      2'd1: r = 8'h72;
      2'd2: r = 8'h75;
      2'd3: r = 8'h65;
    endcase
    return r;
  endfunction

  // letters of "false" by position, positions past the word give the first letter again
  function automatic logic [7:0] false_char(input logic [2:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd0:    r = 8'h66;
      3'd1:    r = 8'h61;
      3'd2:    r = 8'h6C;
      3'd3:    r = 8'h73;
      3'd4:    r = 8'h65;
      default: r = 8'h66;
    endcase
    return r;
  endfunction

  function automatic int_phase_e next_integer(input int_phase_e ph, input logic [7:0] c);
    int_phase_e r;
    unique case (ph)
      INT_START:  r = is_sign(c) ? INT_SIGN : (is_digit(c) ? INT_DIGITS : INT_DEAD);
      INT_SIGN:   r = is_digit(c) ? INT_DIGITS : INT_DEAD;
      INT_DIGITS: r = is_digit(c) ? INT_DIGITS : INT_DEAD;
      default:    r = INT_DEAD;
    endcase
    return r;
  endfunction

  function automatic dec_phase_e next_decimal(input dec_phase_e ph, input logic [7:0] c);
    dec_phase_e r;
    unique case (ph)
      DEC_START: r = is_sign(c) ? DEC_SIGN : (is_digit(c) ? DEC_INT : DEC_DEAD);
      DEC_SIGN:  r = is_digit(c) ? DEC_INT : DEC_DEAD;
      DEC_INT:   r = is_digit(c) ? DEC_INT : ((c == CH_DOT) ? DEC_DOT : DEC_DEAD);
      DEC_DOT:   r = is_digit(c) ? DEC_FRAC : DEC_DEAD;
      DEC_FRAC:  r = is_digit(c) ? DEC_FRAC : DEC_DEAD;
      default:   r = DEC_DEAD;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/cvtc_in_reg.sv
// cvtc_in_reg: input register stage for incoming characters
// depends on cvtc_pkg
module cvtc_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  cvtc_pkg::item_t item_i,
  output logic           valid_o,
  input  logic           advance_i,
  output cvtc_pkg::item_t item_o
);
  import cvtc_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  // free slot or slot drains this cycle
  assign ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: rtl/core/cvtc_recognizer.sv
// cvtc_recognizer: per-character recognizer flags and final type decision
// depends on cvtc_pkg
module cvtc_recognizer (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fire_i,
  input  cvtc_pkg::item_t        item_i,
  output cvtc_pkg::value_type_e  value_type_o
);
  import cvtc_pkg::*;

  logic [2:0] pos_q, pos_d;
  logic       oq_q, oq_d;
  logic       ob_q, ob_d;
  logic       qb_q, qb_d;
  logic       bb_q, bb_d;
  int_phase_e iph_q, iph_d, iph_n;
  dec_phase_e dph_q, dph_d, dph_n;
  logic       ta_q, ta_d, ta_n;
  logic       fa_q, fa_d, fa_n;

  logic [7:0] c;
  logic       first;
  logic       crlf;

  assign c     = item_i.char_code;
  assign first = (pos_q == 3'd0);
  assign crlf  = (c == CH_CR) || (c == CH_LF);

  assign iph_n = next_integer(iph_q, c);
  assign dph_n = next_decimal(dph_q, c);
  assign ta_n  = ta_q && (pos_q < 3'd4) && (true_char(pos_q[1:0]) == c);
  assign fa_n  = fa_q && (pos_q < 3'd5) && (false_char(pos_q) == c);

  // type decision on the final character
  always_comb begin
    priority if (!first && oq_q && !qb_q && (c == CH_QUOTE)) begin
      value_type_o = VT_STRING;
    end else if (iph_n == INT_DIGITS) begin
      value_type_o = VT_INTEGER;
    end else if (dph_n == DEC_FRAC) begin
      value_type_o = VT_DECIMAL;
    end else if ((ta_n && (pos_q == 3'd3)) || (fa_n && (pos_q == 3'd4))) begin
      value_type_o = VT_BOOLEAN;
    end else if (!first && ob_q && !bb_q && (c == CH_RBRACK)) begin
      value_type_o = VT_ARRAY;
    end else begin
      value_type_o = VT_INVALID;
    end
  end

  // state update, back to start after the final character
  always_comb begin
    pos_d = pos_q;
    oq_d  = oq_q;
    ob_d  = ob_q;
    qb_d  = qb_q;
    bb_d  = bb_q;
    iph_d = iph_q;
    dph_d = dph_q;
    ta_d  = ta_q;
    fa_d  = fa_q;
    if (fire_i) begin
      if (item_i.last_char) begin
        pos_d = 3'd0;
        oq_d  = 1'b0;
        ob_d  = 1'b0;
        qb_d  = 1'b0;
        bb_d  = 1'b0;
        iph_d = INT_START;
        dph_d = DEC_START;
        ta_d  = 1'b1;
        fa_d  = 1'b1;
      end else begin
        if (first) begin
          oq_d = (c == CH_QUOTE);
          ob_d = (c == CH_LBRACK);
        end else begin
          if ((c == CH_QUOTE) || crlf) begin
            qb_d = 1'b1;
          end
          if (crlf) begin
            bb_d = 1'b1;
          end
        end
        iph_d = iph_n;
        dph_d = dph_n;
        ta_d  = ta_n;
        fa_d  = fa_n;
        if (pos_q != POS_MAX) begin
          pos_d = pos_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 3'd0;
      oq_q  <= 1'b0;
      ob_q  <= 1'b0;
      qb_q  <= 1'b0;
      bb_q  <= 1'b0;
      iph_q <= INT_START;
      dph_q <= DEC_START;
      ta_q  <= 1'b1;
      fa_q  <= 1'b1;
    end else begin
      pos_q <= pos_d;
      oq_q  <= oq_d;
      ob_q  <= ob_d;
      qb_q  <= qb_d;
      bb_q  <= bb_d;
      iph_q <= iph_d;
      dph_q <= dph_d;
      ta_q  <= ta_d;
      fa_q  <= fa_d;
    end
  end

  // a token end returns every flag to its start value; the quote and bracket break flags go unchecked here
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.last_char |=> (pos_q == 3'd0) && ta_q && fa_q && !oq_q && !ob_q
      && (iph_q == INT_START) && (dph_q == DEC_START))
    else $error("recognizer state not cleared after token end");

  // position counts characters and saturates
  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !item_i.last_char && (pos_q != POS_MAX) |=> pos_q == $past(pos_q) + 3'd1)
    else $error("position did not advance");

  // the first character cannot open both a string and an array
  a_open_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(oq_q && ob_q))
    else $error("quote and bracket both marked as opener");

endmodule

// File: rtl/core/cvtc_out_reg.sv
// cvtc_out_reg: result register holding one type code until taken
// depends on cvtc_pkg
module cvtc_out_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  cvtc_pkg::value_type_e value_type_i,
  output logic                  space_o,
  output logic                  valid_o,
  input  logic                  ready_i,
  output cvtc_pkg::value_type_e value_type_o
);
  import cvtc_pkg::*;

  logic        valid_q, valid_d;
  value_type_e vt_q;

  // can take a new result when empty or being drained
  assign space_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      vt_q <= value_type_i;
    end
  end

  assign valid_o      = valid_q;
  assign value_type_o = vt_q;

endmodule

// File: rtl/core/config_value_type_classifier_unit.sv
// config_value_type_classifier_unit: top level of the value type classifier
// depends on cvtc_pkg, cvtc_in_reg, cvtc_recognizer, cvtc_out_reg
//
//  channel  | dir | tdata                    | tlast     | meaning
//  s_axis   | in  | [7:0] char_code          | last_char | one byte of the token
//  m_axis   | out | [2:0] value_type, 0 pad  | -         | type code, one per token
//
// one character per cycle while no result waits at a token end; an
// item is held in the input register, then the recognizer flags
// update and on the token's last character the type code is written
// to the result register as that character leaves the input register
// reset (async, active low) empties both registers and puts the recognizer
// at token start
// a held result only stalls a last character; other characters keep flowing
module config_value_type_classifier_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] char_code
  input  logic       s_axis_tlast_i,   // last_char
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o    // [2:0] value_type, [7:3] zero
);
  import cvtc_pkg::*;

  item_t       in_item;
  item_t       cur_item;
  logic        cur_valid;
  logic        fire;
  logic        out_space;
  value_type_e vt_comb;
  value_type_e vt_out;

  assign in_item.char_code = s_axis_tdata_i;
  assign in_item.last_char = s_axis_tlast_i;

  // a character moves on unless it ends a token and the result slot is full
  assign fire = cur_valid && (out_space || !cur_item.last_char);

  cvtc_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid_i),
    .ready_o   (s_axis_tready_o),
    .item_i    (in_item),
    .valid_o   (cur_valid),
    .advance_i (fire),
    .item_o    (cur_item)
  );

  cvtc_recognizer u_recognizer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .item_i       (cur_item),
    .value_type_o (vt_comb)
  );

  cvtc_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (fire && cur_item.last_char),
    .value_type_i (vt_comb),
    .space_o      (out_space),
    .valid_o      (m_axis_tvalid_o),
    .ready_i      (m_axis_tready_i),
    .value_type_o (vt_out)
  );

  assign m_axis_tdata_o = {5'd0, vt_out};

  // a token end never overwrites a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && cur_item.last_char |-> !m_axis_tvalid_o || m_axis_tready_i)
    else $error("result register overwritten");

  // a stalled token end holds the input register closed
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid && cur_item.last_char && m_axis_tvalid_o && !m_axis_tready_i
      |-> !s_axis_tready_o)
    else $error("input taken while token end is stalled");

  // a waiting result stays put until taken
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("waiting result changed");

endmodule
